// File: design/blsa_pkg.sv
// ----------------------------------------------------------------------------
// blsa_pkg
// Shared constants and types for the speed-average brake light block.
// ----------------------------------------------------------------------------
package blsa_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int SPEED_BITS = 16;

   localparam int MAG_W    = SPEED_BITS - 1;
   localparam int SLOT_W   = $clog2(MAX_WINDOW);
   localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W    = MAG_W + SLOT_W;
   localparam int FACTOR_W = 16;
   localparam int WLEN_W   = 5;
   localparam int MARGIN_W = 15;
   localparam int PROD_W   = MAG_W + FACTOR_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   localparam logic [FACTOR_W-1:0] ENABLE_FACTOR_RST  = 16'd31130;
   localparam logic [FACTOR_W-1:0] DISABLE_FACTOR_RST = 16'd34079;
   localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RST  = 5'd10;
   localparam logic [MARGIN_W-1:0] DROP_MARGIN_RST    = 15'd128;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_FACTOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISABLE_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_MARGIN    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REPLACE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL_EN,
      ST_MUL_DIS,
      ST_DECIDE
   } blsa_state_type;

endpackage

// File: design/brake_light_from_speed_average.sv
// ----------------------------------------------------------------------------
// brake_light_from_speed_average
// Moving average of speed magnitudes with a hysteresis brake light decision.
//
//   channel | direction | tdata fields (lowest bit up)
//   --------+-----------+--------------------------------------------------
//   req_    | in        | speed_sample[15:0]
//   rsp_    | out       | brake_on[0], brake_changed[1], avg_speed[16:2]
//   csr_    | in        | wen, index (0..3), wdata
//
// Each sample passes through a bit-serial divider (one bit per cycle over the
// 19-bit sum); a new sample is taken only once the last one has been decided.
// Reset is synchronous; the window memory needs no clearing pass because only
// entries written since the last clear are ever read.
// A result waiting on rsp_ does not stop the next sample from being taken;
// the block only holds in its decision step while the output is still full.
// ----------------------------------------------------------------------------
module brake_light_from_speed_average
   import blsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // speed_sample[15:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // brake_on, brake_changed, avg_speed, pad
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   blsa_state_type state_ff, state_in;

   logic [FACTOR_W-1:0] enable_factor_ff;
   logic [FACTOR_W-1:0] disable_factor_ff;
   logic [WLEN_W-1:0]   window_length_ff;
   logic [MARGIN_W-1:0] drop_margin_ff;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              lit_ff, lit_in;
   logic [FILL_W-1:0] len_ff;

   logic signed [SPEED_BITS-1:0] speed_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [PROD_W-1:0] prod_en_ff;
   logic [PROD_W-1:0] prod_dis_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff;
   logic              rsp_load;

   // accept-time values
   logic                         accept;
   logic signed [SPEED_BITS-1:0] speed_in;
   logic [SPEED_BITS-1:0]        abs_val;
   logic [MAG_W-1:0]             mag_in;
   logic [FILL_W-1:0]            len_eff;
   logic [FILL_W-1:0]            fill_norm;
   logic [SLOT_W-1:0]            oldest_norm;
   logic [FILL_W:0]              slot_sum;
   logic [FILL_W:0]              slot_wrap;
   logic [SLOT_W-1:0]            append_slot;
   logic [FILL_W-1:0]            oldest_next;

   // memory ports
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [MAG_W-1:0]  ram_rd_data;

   // divider
   logic              div_start;
   logic              div_done;
   logic [SUM_W-1:0]  div_quot;
   logic [MAG_W-1:0]  avg;
   logic [MAG_W-1:0]  avg_ff;

   // decision
   logic [PROD_W-1:0]         mag_scaled;
   logic signed [SPEED_BITS:0] v_plus_margin;
   logic signed [PROD_W:0]    vm_scaled;
   logic signed [PROD_W:0]    prod_en_s;
   logic                      turn_on;
   logic                      lit_mid;
   logic                      lit_final;

   assign accept = req_tvalid && req_tready;

   // sample magnitude, most negative value saturates
   always_comb begin
      speed_in = $signed(req_tdata);
      abs_val  = speed_in[SPEED_BITS-1] ? (~req_tdata + 1'b1) : req_tdata;
      if (abs_val[SPEED_BITS-1]) begin
         mag_in = MAG_MAX;
      end else begin
         mag_in = abs_val[MAG_W-1:0];
      end
   end

   // effective window length and ring pointers
   always_comb begin
      if (window_length_ff == '0) begin
         len_eff = FILL_W'(1);
      end else if (32'(window_length_ff) > 32'(MAX_WINDOW)) begin
         len_eff = FILL_W'(MAX_WINDOW);
      end else begin
         len_eff = FILL_W'(window_length_ff);
      end
      if ({1'b0, oldest_ff} >= (FILL_W+1)'(len_eff)) begin
         oldest_norm = '0;
      end else begin
         oldest_norm = oldest_ff;
      end
      fill_norm = (fill_ff > len_eff) ? len_eff : fill_ff;
      slot_sum  = (FILL_W+1)'(oldest_norm) + (FILL_W+1)'(fill_norm);
      slot_wrap = slot_sum - (FILL_W+1)'(len_eff);
      if (slot_sum >= (FILL_W+1)'(len_eff)) begin
         append_slot = slot_wrap[SLOT_W-1:0];
      end else begin
         append_slot = slot_sum[SLOT_W-1:0];
      end
      oldest_next = FILL_W'(oldest_ff) + 1'b1;
   end

   assign ram_rd_en   = accept && (fill_norm >= len_eff);
   assign ram_wr_en   = (accept && (fill_norm < len_eff)) || (state_ff == ST_REPLACE);
   assign ram_wr_addr = (state_ff == ST_REPLACE) ? oldest_ff : append_slot;

   blsa_window_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ((state_ff == ST_REPLACE) ? mag_ff : mag_in),
      .rd_en   (ram_rd_en),
      .rd_addr (oldest_norm),
      .rd_data (ram_rd_data)
   );

   assign div_start = (state_ff == ST_DIV_START);

   blsa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign avg = div_quot[MAG_W-1:0];

   // exact comparisons scaled by 2^15
   always_comb begin
      mag_scaled    = {1'b0, mag_ff, {(PROD_W-MAG_W-1){1'b0}}};
      v_plus_margin = (SPEED_BITS+1)'(speed_ff) + $signed({2'b00, drop_margin_ff});
      vm_scaled     = $signed({v_plus_margin, {(PROD_W-SPEED_BITS){1'b0}}});
      prod_en_s     = $signed({1'b0, prod_en_ff});
      turn_on       = !lit_ff && (mag_scaled < prod_en_ff) && (vm_scaled < prod_en_s);
      lit_mid       = lit_ff || turn_on;
      lit_final     = lit_mid && !(mag_scaled > prod_dis_ff);
   end

   assign rsp_load = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      fill_in    = fill_ff;
      oldest_in  = oldest_ff;
      sum_in     = sum_ff;
      lit_in     = lit_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               oldest_in = oldest_norm;
               if (fill_norm < len_eff) begin
                  fill_in  = fill_norm + 1'b1;
                  sum_in   = sum_ff + SUM_W'(mag_in);
                  state_in = ST_DIV_START;
               end else begin
                  fill_in  = fill_norm;
                  state_in = ST_REPLACE;
               end
            end
         end
         ST_REPLACE: begin
            // evicted magnitude arrives from the memory this cycle
            sum_in = sum_ff - SUM_W'(ram_rd_data) + SUM_W'(mag_ff);
            if (oldest_next >= len_ff) begin
               oldest_in = '0;
            end else begin
               oldest_in = oldest_next[SLOT_W-1:0];
            end
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_MUL_EN;
            end
         end
         ST_MUL_EN: begin
            state_in = ST_MUL_DIS;
         end
         ST_MUL_DIS: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (rsp_load) begin
               lit_in   = lit_final;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // window length write clears the window
      if (csr_wen && (csr_index == CSR_WINDOW_LENGTH)) begin
         fill_in   = '0;
         oldest_in = '0;
         sum_in    = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         sum_ff       <= '0;
         lit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         sum_ff       <= sum_in;
         lit_ff       <= lit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_factor_ff  <= ENABLE_FACTOR_RST;
         disable_factor_ff <= DISABLE_FACTOR_RST;
         window_length_ff  <= WINDOW_LENGTH_RST;
         drop_margin_ff    <= DROP_MARGIN_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ENABLE_FACTOR:  enable_factor_ff  <= csr_wdata[FACTOR_W-1:0];
            CSR_DISABLE_FACTOR: disable_factor_ff <= csr_wdata[FACTOR_W-1:0];
            CSR_WINDOW_LENGTH:  window_length_ff  <= csr_wdata[WLEN_W-1:0];
            CSR_DROP_MARGIN:    drop_margin_ff    <= csr_wdata[MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         speed_ff <= speed_in;
         mag_ff   <= mag_in;
         len_ff   <= len_eff;
      end
      if (div_done) begin
         avg_ff <= avg;
      end
      if (state_ff == ST_MUL_EN) begin
         prod_en_ff <= PROD_W'(avg_ff) * PROD_W'(enable_factor_ff);
      end
      if (state_ff == ST_MUL_DIS) begin
         prod_dis_ff <= PROD_W'(avg_ff) * PROD_W'(disable_factor_ff);
      end
      if (rsp_load) begin
         rsp_data_ff <= {7'b0, avg_ff, (lit_final != lit_ff), lit_final};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/blsa_window_ram.sv
// ----------------------------------------------------------------------------
// blsa_window_ram
// Window of speed magnitudes: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module blsa_window_ram
   import blsa_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  logic [MAG_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [MAG_W-1:0]  rd_data
);

   logic [MAG_W-1:0] mem_ff [MAX_WINDOW];
   logic [MAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/blsa_divider.sv
// ----------------------------------------------------------------------------
// blsa_divider
// Restoring divider, one quotient bit per cycle: window sum by fill count.
// ----------------------------------------------------------------------------
module blsa_divider
   import blsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [FILL_W-1:0] divisor,
   output logic              done,
   output logic [SUM_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [FILL_W-1:0] dsr_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [FILL_W:0]   trial;
   logic [FILL_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits back in FILL_W bits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[FILL_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[FILL_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
